### hw/rtl/sha256_stream_hasher_macros.svh
// Assertion macros for the hasher checker.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Same-cycle implication.
`define SHS_AST_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHS_AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/shs_pkg.sv
`default_nettype none
package shs_pkg;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned DigWords   = 8;
	localparam logic [7:0]  PadMark    = 8'h80;
	localparam logic [5:0]  LengthPos  = 6'd56;

	localparam logic [31:0] RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [DigWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef logic [DigWords-1:0][31:0] work_t;

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] sml0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/shs_stream_if.sv
`default_nettype none
interface shs_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_final;
	modport source (output valid, data_byte, has_byte, is_final, input ready);
	modport sink   (input valid, data_byte, has_byte, is_final, output ready);
endinterface

interface shs_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### hw/rtl/shs_round.sv
`default_nettype none
// One compression round: a..h in lanes 0..7.
module shs_round (
	input  wire shs_pkg::work_t wv,
	input  wire logic [31:0]    w_t,
	input  wire logic [31:0]    k_t,
	output shs_pkg::work_t      wv_nxt
);
	logic [31:0] ch, maj, t1, t2;

	always_comb begin
		ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
		maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
		t1  = wv[7] + shs_pkg::big1(wv[4]) + ch + k_t + w_t;
		t2  = shs_pkg::big0(wv[0]) + maj;
		wv_nxt[7] = wv[6];
		wv_nxt[6] = wv[5];
		wv_nxt[5] = wv[4];
		wv_nxt[4] = wv[3] + t1;
		wv_nxt[3] = wv[2];
		wv_nxt[2] = wv[1];
		wv_nxt[1] = wv[0];
		wv_nxt[0] = t1 + t2;
	end
endmodule
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
`default_nettype none
// Streaming SHA-256 hasher.
// msg (sink): one beat carries an optional message byte (has_byte) and an
//   optional end mark (is_final). A beat with neither does nothing.
// dig (source): eight beats per message, digest word 0 (high) first,
//   word_index counts 0..7, last_word marks the eighth beat.
// Bytes are packed into 32-bit words and stored in a 16-word block memory
// (one write port, one read port, registered read). Each full block runs
// 64 rounds, one per cycle, from that memory plus a 16-word schedule line.
// Byte beats are taken back to back while idle; the 64th byte of a block
// starts the load, the rounds and the chain update, with msg.ready low.
// The end beat injects padding one byte per cycle (plus one extra
// compression when fewer than 9 bytes remain in the block), then the
// digest beats start; the first digest beat follows the chain update of
// the last compression.
// msg.ready is low while padding, compressing or emitting the digest.
// If dig.ready is low the current digest beat holds until taken.
// After the last digest beat the chaining state returns to the initial
// value and a new message may begin. Reset (arst_n low) does the same at
// once; the block memory is not cleared since padding rewrites it.
module sha256_stream_hasher (
	input  wire logic  clk,
	input  wire logic  arst_n,
	shs_msg_if.sink    msg,
	shs_dig_if.source  dig
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLoad = 3'd2;
	localparam logic [2:0] StCmp  = 3'd3;
	localparam logic [2:0] StFin  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;       // bytes in the block
	logic [23:0] wacc_q;       // partial word
	logic [63:0] len_q;        // message bytes absorbed
	logic [63:0] lenbits_q;    // bit length, shifted out high byte first
	logic        pad_q;        // message end seen
	logic        mark_q;       // 0x80 placed
	logic        lenok_q;      // length fits in the current block
	logic        done_q;       // current compression is the last one
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	shs_pkg::work_t h_q, wv_q, wv_nxt;
	logic [15:0][31:0] w_q;    // W[t-16] .. W[t-1]

	// block memory
	logic [31:0] blk_mem [shs_pkg::BlockWords];
	logic [31:0] rd_s1;
	logic [3:0]  raddr;
	logic        wen;
	logic [3:0]  waddr;
	logic [31:0] wdata;

	logic        acc;
	logic        absorb_en;
	logic [7:0]  absorb_byte;
	logic        blk_full;
	logic [63:0] len_nxt;
	logic [31:0] w_sched, w_t;

	assign msg.ready = (state_q == StIdle);
	assign acc       = msg.valid && msg.ready;

	// Byte source: input beats while idle, padding bytes while padding.
	always_comb begin
		absorb_en   = 1'b0;
		absorb_byte = 8'h00;
		unique case (state_q)
			StIdle: begin
				absorb_en   = acc && msg.has_byte;
				absorb_byte = msg.data_byte;
			end
			StPad: begin
				absorb_en = 1'b1;
				if (!mark_q) begin
					absorb_byte = shs_pkg::PadMark;
				end else if (lenok_q && fill_q >= shs_pkg::LengthPos) begin
					absorb_byte = lenbits_q[63:56];
				end
			end
			default: begin
				absorb_en = 1'b0;
			end
		endcase
	end

	assign blk_full = absorb_en && (fill_q == 6'd63);
	assign wen      = absorb_en && (fill_q[1:0] == 2'b11);
	assign waddr    = fill_q[5:2];
	assign wdata    = {wacc_q, absorb_byte};
	assign len_nxt  = len_q + {63'd0, msg.has_byte};

	// Writes only happen in idle/pad, read data is only used in load/compress: no overlap.
	assign raddr = (state_q == StLoad) ? 4'd0 : (rnd_q[3:0] + 4'd1);

	always_ff @(posedge clk) begin
		if (wen) begin
			blk_mem[waddr] <= wdata;
		end
		rd_s1 <= blk_mem[raddr];
	end

	assign w_sched = w_q[0] + shs_pkg::sml0(w_q[1]) + w_q[9] + shs_pkg::sml1(w_q[14]);
	assign w_t     = (rnd_q[5:4] == 2'b00) ? rd_s1 : w_sched;

	shs_round u_round (
		.wv     (wv_q),
		.w_t    (w_t),
		.k_t    (shs_pkg::RoundK[rnd_q]),
		.wv_nxt (wv_nxt)
	);

	// Working registers and schedule line: payload, no reset.
	always_ff @(posedge clk) begin
		if (state_q == StLoad) begin
			wv_q <= h_q;
		end else if (state_q == StCmp) begin
			wv_q <= wv_nxt;
			w_q  <= {w_t, w_q[15:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			fill_q    <= '0;
			wacc_q    <= '0;
			len_q     <= '0;
			lenbits_q <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			lenok_q   <= 1'b0;
			done_q    <= 1'b0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			for (int i = 0; i < shs_pkg::DigWords; i++) begin
				h_q[i] <= shs_pkg::InitHash[i];
			end
		end else begin
			if (absorb_en) begin
				fill_q <= fill_q + 6'd1;
				wacc_q <= {wacc_q[15:0], absorb_byte};
			end
			unique case (state_q)
				StIdle: begin
					if (acc) begin
						if (msg.has_byte) begin
							len_q <= len_nxt;
						end
						if (msg.is_final) begin
							pad_q     <= 1'b1;
							mark_q    <= 1'b0;
							lenok_q   <= 1'b0;
							lenbits_q <= {len_nxt[60:0], 3'b000};
						end
						if (blk_full) begin
							done_q  <= 1'b0;
							state_q <= StLoad;
						end else if (msg.is_final) begin
							state_q <= StPad;
						end
					end
				end
				StPad: begin
					mark_q <= 1'b1;
					if (mark_q && lenok_q && fill_q >= shs_pkg::LengthPos) begin
						lenbits_q <= {lenbits_q[55:0], 8'h00};
					end
					// mark in the last slot: lenok_q is still clear from idle
					if (blk_full) begin
						done_q  <= lenok_q;
						lenok_q <= 1'b1;
						state_q <= StLoad;
					end else if (!mark_q) begin
						lenok_q <= (fill_q < shs_pkg::LengthPos);
					end
				end
				StLoad: begin
					rnd_q   <= '0;
					state_q <= StCmp;
				end
				StCmp: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= StFin;
					end
				end
				StFin: begin
					for (int i = 0; i < shs_pkg::DigWords; i++) begin
						h_q[i] <= h_q[i] + wv_q[i];
					end
					oidx_q <= '0;
					if (!pad_q) begin
						state_q <= StIdle;
					end else if (done_q) begin
						state_q <= StOut;
					end else begin
						state_q <= StPad;
					end
				end
				StOut: begin
					if (dig.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= StIdle;
							len_q   <= '0;
							pad_q   <= 1'b0;
							for (int i = 0; i < shs_pkg::DigWords; i++) begin
								h_q[i] <= shs_pkg::InitHash[i];
							end
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign dig.valid       = (state_q == StOut);
	assign dig.digest_word = h_q[oidx_q];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == 3'd7);
endmodule
`default_nettype wire

### hw/rtl/shs_checker.sv
`default_nettype none
`include "sha256_stream_hasher_macros.svh"
module shs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        msg_ready,
	input wire logic        dig_valid,
	input wire logic        dig_ready,
	input wire logic [31:0] dig_word,
	input wire logic [2:0]  dig_index,
	input wire logic        dig_last
);
	// stalled digest beat holds
	`SHS_AST_NEXT(a_dig_hold, clk, arst_n, dig_valid && !dig_ready, dig_valid && $stable(dig_word) && $stable(dig_index), "digest beat changed while stalled")
	// words come in order
	`SHS_AST_NEXT(a_dig_order, clk, arst_n, dig_valid && dig_ready && !dig_last, dig_valid && (dig_index == $past(dig_index) + 3'd1), "digest word out of order")
	// digest ends after the last word
	`SHS_AST_NEXT(a_dig_end, clk, arst_n, dig_valid && dig_ready && dig_last, !dig_valid, "digest ran past last word")
	// no input taken while the digest is out
	`SHS_AST_SAME(a_no_in, clk, arst_n, dig_valid, !msg_ready, "input accepted during digest")
endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_ready (msg.ready),
	.dig_valid (dig.valid),
	.dig_ready (dig.ready),
	.dig_word  (dig.digest_word),
	.dig_index (dig.word_index),
	.dig_last  (dig.last_word)
);
`default_nettype wire

### sim/tb_sha256_stream_hasher.sv
`default_nettype none
module tb_sha256_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	// one digest beat as the sink should see it
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	// directed stimulus row; ref_word0 is only meaningful when has_ref is set
	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        fin;
		logic        has_ref;
		logic [31:0] ref_word0;
	} stim_row_t;

	localparam int NumRows = 14;
	localparam int LongHold = 400;

	logic clk;
	logic arst_n;

	shs_msg_if msg_bus ();
	shs_dig_if dig_bus ();

	sha256_stream_hasher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_bus),
		.dig    (dig_bus)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor state: chaining words, block bytes, fill level, byte count
	// ------------------------------------------------------------------
	logic [31:0] chain_q [8];
	logic [7:0]  block_q [64];
	int unsigned fill_q;
	logic [63:0] byte_count_q;

	digest_beat_t digest_fifo [$];

	int unsigned errors;
	int unsigned beats_sent;
	int unsigned beats_taken;
	int unsigned msgs_done;
	int          idle_pct;
	int          stall_pct;
	bit          hold_req;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain_q[i] = shs_pkg::InitHash[i];
		fill_q = 0;
		byte_count_q = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] r [8];
		logic [31:0] s0, s1, t1, t2, ch, mj;
		for (int i = 0; i < 16; i++)
			w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			r[i] = chain_q[i];
		for (int i = 0; i < 64; i++) begin
			ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
			t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25)) + ch
				+ shs_pkg::RoundK[i] + w[i];
			mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
			t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22)) + mj;
			r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
			r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_q[i] = chain_q[i] + r[i];
	endtask

	// Advance the predictor by one accepted msg beat; queues 8 digest beats on end.
	task automatic hash_beat(input logic [7:0] b, input logic h, input logic f);
		logic [63:0]  bits;
		digest_beat_t d;
		if (h) begin
			block_q[fill_q] = b;
			fill_q++;
			byte_count_q++;
			if (fill_q == 64) begin
				compress_block();
				fill_q = 0;
			end
		end
		if (f) begin
			bits = byte_count_q << 3;
			block_q[fill_q] = shs_pkg::PadMark;
			fill_q++;
			// no room for the length field: pad out and run an extra block
			if (fill_q > 56) begin
				for (int i = fill_q; i < 64; i++)
					block_q[i] = 8'h00;
				compress_block();
				fill_q = 0;
			end
			for (int i = fill_q; i < 56; i++)
				block_q[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				block_q[63-i] = bits[8*i +: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				d.word = chain_q[i];
				d.idx  = i[2:0];
				d.last = (i == 7);
				digest_fifo.push_back(d);
			end
			restart_hash();
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: one msg beat, random idle gaps before it
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] b, input logic h, input logic f);
		while ($urandom_range(99) < idle_pct) begin
			msg_bus.valid     <= 1'b0;
			msg_bus.data_byte <= 8'($urandom);
			@(posedge clk);
		end
		msg_bus.valid     <= 1'b1;
		msg_bus.data_byte <= b;
		msg_bus.has_byte  <= h;
		msg_bus.is_final  <= f;
		do
			@(posedge clk);
		while (!msg_bus.ready);
		beats_sent++;
		hash_beat(b, h, f);
	endtask

	task automatic wait_drained();
		msg_bus.valid <= 1'b0;
		while (digest_fifo.size() != 0)
			@(posedge clk);
	endtask

	// random message; length biased toward the padding boundaries
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			// stray empty beats now and then; the block must ignore them
			if ($urandom_range(9) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
			if (msg_bus.is_final)
				return;
		end
		send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic int pick_length();
		int edges [6] = '{55, 56, 57, 63, 64, 65};
		if ($urandom_range(99) < 70)
			return $urandom_range(0, 12);
		return edges[$urandom_range(5)];
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls, long hold-off on request, compare each beat
	// ------------------------------------------------------------------
	initial begin
		int           hold_left;
		digest_beat_t exp_beat;
		hold_left = 0;
		dig_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dig_bus.valid && dig_bus.ready) begin
				beats_taken++;
				if (digest_fifo.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: digest beat with nothing expected: %h idx %0d",
							$realtime, dig_bus.digest_word, dig_bus.word_index);
				end else begin
					exp_beat = digest_fifo.pop_front();
					if (dig_bus.digest_word !== exp_beat.word ||
					    dig_bus.word_index !== exp_beat.idx ||
					    dig_bus.last_word !== exp_beat.last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: exp %h idx %0d last %0b, got %h idx %0d last %0b",
								$realtime, exp_beat.word, exp_beat.idx, exp_beat.last,
								dig_bus.digest_word, dig_bus.word_index,
								dig_bus.last_word);
					end
					if (exp_beat.last)
						msgs_done++;
				end
			end
			if (hold_req) begin
				hold_left = LongHold;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dig_bus.ready <= 1'b0;
			end else
				dig_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// directed rows: empty message, ignored beat, boundary bytes, "abc"
		stim_row_t rows [NumRows] = '{
			'{8'h5a, 1'b0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
			'{8'ha5, 1'b0, 1'b0, 1'b0, 32'h0},         // no byte, no end
			'{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},         // byte and end together
			'{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
			'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},  // "abc"
			'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h63, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'hff, 1'b0, 1'b1, 1'b1, 32'hba7816bf},  // "abc", end with no byte
			'{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h7f, 1'b1, 1'b1, 1'b0, 32'h0}
		};
		int phase_beats;
		int wait_cnt;

		errors = 0;
		beats_sent = 0;
		beats_taken = 0;
		msgs_done = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		restart_hash();
		arst_n            <= 1'b0;
		msg_bus.valid     <= 1'b0;
		msg_bus.data_byte <= 8'h00;
		msg_bus.has_byte  <= 1'b0;
		msg_bus.is_final  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumRows; i++) begin
			send_beat(rows[i].data, rows[i].has, rows[i].fin);
			// typed-in digests must agree with what the predictor just queued
			if (rows[i].has_ref &&
			    digest_fifo[digest_fifo.size() - 8].word !== rows[i].ref_word0) begin
				errors++;
				if (errors <= 10)
					$display("row %0d: known digest %h, predicted %h", i,
						rows[i].ref_word0, digest_fifo[digest_fifo.size() - 8].word);
			end
		end
		wait_drained();

		// idling phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			unique case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			phase_beats = beats_sent;
			if (ph == 0) begin
				// long sink hold-off while a full block plus digest backs up
				hold_req = 1'b1;
				send_message(64);
				send_message(3);
			end
			while (beats_sent - phase_beats < 12)
				send_message(pick_length());
			// pause the sender until every digest beat has come back
			wait_drained();
		end

		wait_cnt = 0;
		while (wait_cnt < 200) begin
			@(posedge clk);
			wait_cnt++;
		end

		$display("Ran %0d msg beats through %0d messages, %0d digest beats checked,",
			beats_sent, msgs_done, beats_taken);
		$display("across sender/receiver idle mixes and a long sink hold-off.");
		if (errors == 0 && digest_fifo.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/shs_pkg.sv
hw/rtl/shs_stream_if.sv
hw/rtl/shs_round.sv
hw/rtl/sha256_stream_hasher.sv
hw/rtl/shs_checker.sv
sim/tb_sha256_stream_hasher.sv
